>>> rtl/core/srtf_pkg.sv
// shared types and constants for the srtf tick scheduler
package srtf_pkg;

    localparam int MAX_TASKS_DEF = 64;
    localparam int TIME_BITS_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int FIELD_W  = 16;
    localparam int NUM_W    = 7;
    localparam int SUM_W    = 22;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD  = 2'd0,
        K_TICK  = 2'd1,
        K_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_TAT,
        S_WT,
        S_SUM,
        S_OUT
    } t_state;

endpackage

>>> rtl/core/srtf_tick_scheduler_top.sv
// top level of the shortest-remaining-time-first tick scheduler
//
// input channel (i_in_valid / o_in_ready) carries one request: kind 0 loads a
// task (arrival, burst) into the next table slot, kind 1 runs one time tick,
// kind 2 clears the table, time and sums. every request gives exactly one
// result on the output channel (o_out_valid / i_out_ready).
// one request is in work at a time; o_in_ready is high only while idle.
// load, clear and the unused kind: result valid 1 cycle after the request is
// taken, and the next request can be taken one cycle after that.
// tick: the single compare unit walks the task table, one entry per cycle
// through the ram read port; the update, turnaround, waiting-time and sum states
// then run in turn before the result goes to the output state.
// a result waits in the output register while the receiver stalls; the
// sequencer holds its finished result until that register frees up, and
// the next request is taken once the result has moved there.
// reset clears the task count, time, sums and all handshake state; table
// entries are never read before they are written, so the ram is not swept.
module srtf_tick_scheduler_top #(
    parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [srtf_pkg::KIND_W-1:0] i_kind,
    input  logic [srtf_pkg::FIELD_W-1:0] i_arrival_time,
    input  logic [srtf_pkg::FIELD_W-1:0] i_burst_time,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [srtf_pkg::NUM_W-1:0]  o_task_number,
    output logic [srtf_pkg::FIELD_W-1:0] o_time_now,
    output logic                        o_completed,
    output logic [srtf_pkg::FIELD_W-1:0] o_turnaround,
    output logic [srtf_pkg::FIELD_W-1:0] o_waiting,
    output logic [srtf_pkg::SUM_W-1:0]  o_total_turnaround,
    output logic [srtf_pkg::SUM_W-1:0]  o_total_waiting,
    output logic                        o_table_full
);

    localparam int TB    = TIME_BITS;
    localparam int AW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int SW    = srtf_pkg::SUM_W;
    localparam int ADD_W = ((TB > SW) ? TB : SW) + 1;
    localparam int RAM_W = 3 * TB;

    localparam logic [TB-1:0]    TIME_MAX = {TB{1'b1}};
    localparam logic [SW-1:0]    SUM_MAX  = {SW{1'b1}};
    localparam logic [CW-1:0]    COUNT_MAX = CW'(MAX_TASKS);

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [TB-1:0] b);
        logic [ADD_W-1:0] s;
        s = ADD_W'(a) + ADD_W'(b);
        return (s > ADD_W'(SUM_MAX)) ? SUM_MAX : SW'(s);
    endfunction

    srtf_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [TB-1:0] r_clock, n_clock;
    logic [SW-1:0] r_sum_t, n_sum_t;
    logic [SW-1:0] r_sum_w, n_sum_w;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_chk_vld, n_chk_vld;
    logic          r_out_valid, n_out_valid;

    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic          r_found, n_found;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic [TB-1:0] r_best_arr, n_best_arr;
    logic [TB-1:0] r_best_bst, n_best_bst;
    logic [TB-1:0] r_best_rem, n_best_rem;
    logic          r_tick, n_tick;
    logic          r_full, n_full;
    logic          r_done, n_done;
    logic [TB-1:0] r_tat, n_tat;
    logic [TB-1:0] r_wt, n_wt;

    logic [srtf_pkg::NUM_W-1:0]   r_o_num, n_o_num;
    logic [srtf_pkg::FIELD_W-1:0] r_o_time, n_o_time;
    logic                         r_o_done, n_o_done;
    logic [srtf_pkg::FIELD_W-1:0] r_o_tat, n_o_tat;
    logic [srtf_pkg::FIELD_W-1:0] r_o_wt, n_o_wt;
    logic [SW-1:0]                r_o_sum_t, n_o_sum_t;
    logic [SW-1:0]                r_o_sum_w, n_o_sum_w;
    logic                         r_o_full, n_o_full;

    logic             w_accept;
    logic             w_out_free;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [RAM_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [RAM_W-1:0] w_rdata;
    logic [TB-1:0]    w_in_arr;
    logic [TB-1:0]    w_in_bst;
    logic [TB-1:0]    w_rd_arr;
    logic [TB-1:0]    w_rd_bst;
    logic [TB-1:0]    w_rd_rem;
    logic             w_elig;

    assign o_in_ready = (r_state == srtf_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_arr   = TB'(i_arrival_time);
    assign w_in_bst   = TB'(i_burst_time);
    assign w_rd_arr   = w_rdata[3*TB-1:2*TB];
    assign w_rd_bst   = w_rdata[2*TB-1:TB];
    assign w_rd_rem   = w_rdata[TB-1:0];
    assign w_elig     = (w_rd_arr <= r_clock) && (w_rd_rem != '0) &&
                        (!r_found || (w_rd_rem < r_best_rem));

    srtf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srtf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_kind == srtf_pkg::K_TICK) ? srtf_pkg::S_SCAN
                                                           : srtf_pkg::S_OUT;
                end
            end
            srtf_pkg::S_SCAN: begin
                if ((r_rd_idx >= r_count) && !r_chk_vld) begin
                    n_state = srtf_pkg::S_UPD;
                end
            end
            srtf_pkg::S_UPD: n_state = srtf_pkg::S_TAT;
            srtf_pkg::S_TAT: n_state = srtf_pkg::S_WT;
            srtf_pkg::S_WT:  n_state = srtf_pkg::S_SUM;
            srtf_pkg::S_SUM: n_state = srtf_pkg::S_OUT;
            srtf_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = srtf_pkg::S_IDLE;
                end
            end
            default: n_state = srtf_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_count     = r_count;
        n_clock     = r_clock;
        n_sum_t     = r_sum_t;
        n_sum_w     = r_sum_w;
        n_rd_idx    = r_rd_idx;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_arr  = r_best_arr;
        n_best_bst  = r_best_bst;
        n_best_rem  = r_best_rem;
        n_tick      = r_tick;
        n_full      = r_full;
        n_done      = r_done;
        n_tat       = r_tat;
        n_wt        = r_wt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_num     = r_o_num;
        n_o_time    = r_o_time;
        n_o_done    = r_o_done;
        n_o_tat     = r_o_tat;
        n_o_wt      = r_o_wt;
        n_o_sum_t   = r_o_sum_t;
        n_o_sum_w   = r_o_sum_w;
        n_o_full    = r_o_full;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = {w_in_arr, w_in_bst, w_in_bst};
        w_raddr     = r_rd_idx[AW-1:0];

        unique case (r_state)
            srtf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_tick  = 1'b0;
                    n_full  = 1'b0;
                    n_done  = 1'b0;
                    n_found = 1'b0;
                    n_tat   = '0;
                    n_wt    = '0;
                    unique case (i_kind)
                        srtf_pkg::K_LOAD: begin
                            if (r_count < COUNT_MAX) begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_full = 1'b1;
                            end
                        end
                        srtf_pkg::K_TICK: begin
                            n_tick    = 1'b1;
                            n_rd_idx  = '0;
                            n_chk_vld = 1'b0;
                        end
                        srtf_pkg::K_CLEAR: begin
                            n_count = '0;
                            n_clock = '0;
                            n_sum_t = '0;
                            n_sum_w = '0;
                        end
                        default: ;
                    endcase
                end
            end
            srtf_pkg::S_SCAN: begin
                if (r_chk_vld && w_elig) begin
                    n_found    = 1'b1;
                    n_best_idx = r_chk_idx;
                    n_best_arr = w_rd_arr;
                    n_best_bst = w_rd_bst;
                    n_best_rem = w_rd_rem;
                end
                if (r_rd_idx < r_count) begin
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_chk_idx = r_rd_idx[AW-1:0];
                    n_chk_vld = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
            end
            srtf_pkg::S_UPD: begin
                if (r_clock != TIME_MAX) begin
                    n_clock = r_clock + TB'(1);
                end
                if (r_found) begin
                    w_we       = 1'b1;
                    w_waddr    = r_best_idx;
                    w_wdata    = {r_best_arr, r_best_bst, r_best_rem - TB'(1)};
                    n_best_rem = r_best_rem - TB'(1);
                    n_done     = (r_best_rem == TB'(1));
                end
            end
            srtf_pkg::S_TAT: begin
                if (r_done) begin
                    n_tat = r_clock - r_best_arr;
                end
            end
            srtf_pkg::S_WT: begin
                if (r_done) begin
                    n_wt    = (r_tat >= r_best_bst) ? (r_tat - r_best_bst) : '0;
                    n_sum_t = sat_add(r_sum_t, r_tat);
                end
            end
            srtf_pkg::S_SUM: begin
                if (r_done) begin
                    n_sum_w = sat_add(r_sum_w, r_wt);
                end
            end
            srtf_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_num     = (r_tick && r_found)
                                  ? srtf_pkg::NUM_W'(CW'(r_best_idx) + CW'(1)) : '0;
                    n_o_time    = srtf_pkg::FIELD_W'(r_clock);
                    n_o_done    = r_done;
                    n_o_tat     = srtf_pkg::FIELD_W'(r_tat);
                    n_o_wt      = srtf_pkg::FIELD_W'(r_wt);
                    n_o_sum_t   = r_sum_t;
                    n_o_sum_w   = r_sum_w;
                    n_o_full    = r_full;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srtf_pkg::S_IDLE;
            r_count     <= '0;
            r_clock     <= '0;
            r_sum_t     <= '0;
            r_sum_w     <= '0;
            r_rd_idx    <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clock     <= n_clock;
            r_sum_t     <= n_sum_t;
            r_sum_w     <= n_sum_w;
            r_rd_idx    <= n_rd_idx;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best_arr <= n_best_arr;
        r_best_bst <= n_best_bst;
        r_best_rem <= n_best_rem;
        r_tick     <= n_tick;
        r_full     <= n_full;
        r_done     <= n_done;
        r_tat      <= n_tat;
        r_wt       <= n_wt;
        r_o_num    <= n_o_num;
        r_o_time   <= n_o_time;
        r_o_done   <= n_o_done;
        r_o_tat    <= n_o_tat;
        r_o_wt     <= n_o_wt;
        r_o_sum_t  <= n_o_sum_t;
        r_o_sum_w  <= n_o_sum_w;
        r_o_full   <= n_o_full;
    end

    assign o_out_valid        = r_out_valid;
    assign o_task_number      = r_o_num;
    assign o_time_now         = r_o_time;
    assign o_completed        = r_o_done;
    assign o_turnaround       = r_o_tat;
    assign o_waiting          = r_o_wt;
    assign o_total_turnaround = r_o_sum_t;
    assign o_total_waiting    = r_o_sum_w;
    assign o_table_full       = r_o_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("task count above table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("ready again right after a request");

    a_full_is_not_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> ((o_task_number == '0) && !o_completed))
        else $error("dropped load reports a running task");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srtf_pkg::S_SCAN) |-> !w_we)
        else $error("table written during scan");

endmodule

>>> rtl/core/srtf_ram.sv
// generic single write port ram with registered read
module srtf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
